@@ sv/chtab_pkg.sv @@
package chtab_pkg;

  localparam int KeyBits    = 16;
  localparam int MaxBuckets = 64;
  localparam int PoolNodes  = 256;
  localparam int BucketBits = 6;
  localparam int LinkBits   = 9;
  localparam int NodeBits   = 8;
  localparam int PosBits    = 9;
  localparam int CollBits   = 8;
  localparam int SizeBits   = 7;
  localparam int CntBits    = 4;

  localparam logic [SizeBits-1:0] SizeReset = 7'd11;
  localparam logic [SizeBits-1:0] SizeMax   = 7'd64;
  localparam logic [CollBits-1:0] CollMax   = 8'd255;
  localparam logic [LinkBits-1:0] PoolLimit = 9'd256;

  localparam logic KindInsert = 1'b0;
  localparam logic KindSearch = 1'b1;

  localparam logic RegTableSize = 1'b0;

  typedef struct packed {
    logic                kind;
    logic [KeyBits-1:0]  key;
  } in_item_t;

  typedef struct packed {
    logic                  found;
    logic [BucketBits-1:0] bucket;
    logic [PosBits-1:0]    position;
    logic                  pool_full;
    logic [CollBits-1:0]   collisions;
  } out_item_t;

  typedef struct packed {
    logic [KeyBits-1:0]  key;
    logic [LinkBits-1:0] next;
  } node_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_HEAD,
    S_DECIDE,
    S_NODE,
    S_CMP
  } state_t;

endpackage

@@ sv/chained_hash_table.sv @@
// channel   | signals                                   | direction
// ----------+-------------------------------------------+----------
// command   | start, busy, cmd (kind, key)              | in
// result    | done, res (found, bucket, position, ...)  | out
// config    | psel penable pwrite paddr pwdata prdata   | in/out
//
// an item goes through a bit-serial modulo and a bucket head read, then a
// search does a node memory read and a compare per chain node visited;
// an insert ends right after the head read.
// busy is high from the accepting edge until the result strobe.
// reset and a size register write empty the table at once (head valid bits).
// the result is shown for one cycle with done; the receiver cannot stall.
module chained_hash_table
  import chtab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    cmd,
  output logic        done,
  output out_item_t   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t state, state_next;

  logic [SizeBits-1:0]   size_cfg;
  logic [SizeBits-1:0]   divisor;
  logic [MaxBuckets-1:0] head_valid;
  logic [LinkBits-1:0]   nodes_used;
  logic [CollBits-1:0]   coll;
  logic [CollBits-1:0]   coll_next;

  logic                  kind;
  logic [KeyBits-1:0]    key;
  logic [SizeBits-1:0]   rem;
  logic [SizeBits-1:0]   trial;
  logic [CntBits-1:0]    cnt;
  logic [LinkBits-1:0]   link;
  logic [PosBits-1:0]    pos;
  logic [LinkBits-1:0]   head;
  logic [BucketBits-1:0] bucket;

  logic                  cfg_wr;
  logic                  head_we;
  logic [LinkBits-1:0]   head_rdata;
  logic                  node_we;
  logic [NodeBits-1:0]   node_raddr;
  node_t                 node_wdata;
  node_t                 node_rdata;
  logic                  pool_empty;
  logic                  key_hit;

  assign pready = 1'b1;
  assign prdata = {{(32-SizeBits){1'b0}}, size_cfg};
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegTableSize);
  assign busy   = (state != S_IDLE);

  // table size zero acts as one bucket, above the maximum as the maximum
  always_comb begin
    if (size_cfg == '0) begin
      divisor = SizeBits'(1);
    end else if (size_cfg > SizeMax) begin
      divisor = SizeMax;
    end else begin
      divisor = size_cfg;
    end
  end

  // one step of restoring modulo: shift in a key bit, subtract if it fits
  always_comb begin
    trial = {rem[SizeBits-2:0], key[cnt]};
    if (trial >= divisor) begin
      trial = trial - divisor;
    end
  end

  assign bucket     = rem[BucketBits-1:0];
  assign head       = head_valid[bucket] ? head_rdata : '0;
  assign pool_empty = (nodes_used >= PoolLimit);
  assign key_hit    = (node_rdata.key == key);
  assign coll_next  = (head != '0 && coll < CollMax) ? coll + CollBits'(1) : coll;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_DIV;
      S_DIV:    if (cnt == '0) state_next = S_HEAD;
      S_HEAD:   state_next = S_DECIDE;
      S_DECIDE: begin
        if (kind == KindSearch && head != '0) begin
          state_next = S_NODE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_NODE:   state_next = S_CMP;
      S_CMP: begin
        if (key_hit || node_rdata.next == '0) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_NODE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    head_we    = (state == S_DECIDE) && (kind == KindInsert) && !pool_empty;
    node_we    = head_we;
    node_wdata = '{key: key, next: head};
    node_raddr = NodeBits'(link - LinkBits'(1));
  end

  chtab_ram #(
    .WIDTH (LinkBits),
    .DEPTH (MaxBuckets)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (bucket),
    .wdata (nodes_used + LinkBits'(1)),
    .raddr (bucket),
    .rdata (head_rdata)
  );

  chtab_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (PoolNodes)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (nodes_used[NodeBits-1:0]),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      size_cfg   <= SizeReset;
      head_valid <= '0;
      nodes_used <= '0;
      coll       <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_wr) begin
        size_cfg   <= pwdata[SizeBits-1:0];
        head_valid <= '0;
        nodes_used <= '0;
        coll       <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            kind <= cmd.kind;
            key  <= cmd.key;
            rem  <= '0;
            cnt  <= CntBits'(KeyBits - 1);
          end
        end
        S_DIV: begin
          rem <= trial;
          cnt <= cnt - CntBits'(1);
        end
        S_HEAD: begin
        end
        S_DECIDE: begin
          res.bucket    <= bucket;
          res.pool_full <= 1'b0;
          res.found     <= 1'b0;
          res.position  <= '0;
          res.collisions <= coll;
          link <= head;
          pos  <= PosBits'(1);
          if (kind == KindInsert) begin
            done <= 1'b1;
            if (pool_empty) begin
              res.pool_full <= 1'b1;
            end else begin
              head_valid[bucket] <= 1'b1;
              nodes_used         <= nodes_used + LinkBits'(1);
              coll               <= coll_next;
              res.collisions     <= coll_next;
              res.found          <= 1'b1;
              res.position       <= PosBits'(1);
            end
          end else if (head == '0) begin
            done <= 1'b1;
          end
        end
        S_NODE: begin
        end
        S_CMP: begin
          if (key_hit) begin
            done         <= 1'b1;
            res.found    <= 1'b1;
            res.position <= pos;
          end else if (node_rdata.next == '0) begin
            done <= 1'b1;
          end else begin
            link <= node_rdata.next;
            pos  <= pos + PosBits'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/chtab_ram.sv @@
module chtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/tb.sv @@
module tb;
  import chtab_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 2000;
  localparam int TailCycles = 600;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_item_t    cmd;
  logic        done;
  out_item_t   res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  chained_hash_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .res(res), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // table mirror; links hold node index + 1, 0 is null
  logic [LinkBits-1:0] head_link [MaxBuckets];
  logic [KeyBits-1:0]  pool_key [PoolNodes];
  logic [LinkBits-1:0] pool_next [PoolNodes];
  int unsigned         alloc_count;
  int unsigned         coll_count;
  int unsigned         buckets_used;

  out_item_t expected_q[$];
  int        errors;
  int        items_sent;
  int        results_seen;
  int        idle_cycles;
  int        size_settings;
  int        found_hits;
  int        drops;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  task automatic clear_mirror(input int size_val);
    for (int i = 0; i < MaxBuckets; i++) head_link[i] = '0;
    alloc_count = 0;
    coll_count = 0;
    if (size_val == 0) buckets_used = 1;
    else if (size_val > MaxBuckets) buckets_used = MaxBuckets;
    else buckets_used = size_val;
  endtask

  function automatic out_item_t predict_lookup(input in_item_t item);
    out_item_t r;
    int unsigned b;
    int unsigned link;
    int unsigned pos;
    r = '0;
    b = item.key % buckets_used;
    r.bucket = b[BucketBits-1:0];
    if (item.kind == KindInsert) begin
      if (alloc_count >= PoolNodes) begin
        r.pool_full = 1'b1;
      end else begin
        if (head_link[b] != 0 && coll_count < CollMax) coll_count++;
        pool_key[alloc_count] = item.key;
        pool_next[alloc_count] = head_link[b];
        alloc_count++;
        head_link[b] = alloc_count[LinkBits-1:0];
        r.found = 1'b1;
        r.position = PosBits'(1);
      end
    end else begin
      link = 32'(head_link[b]);
      pos = 1;
      while (link != 0) begin
        if (pool_key[link-1] == item.key) begin
          r.found = 1'b1;
          r.position = pos[PosBits-1:0];
          break;
        end
        link = 32'(pool_next[link-1]);
        pos++;
      end
    end
    r.collisions = coll_count[CollBits-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (res.found != want.found) report_mismatch("found", res.found, want.found);
        if (res.bucket != want.bucket) report_mismatch("bucket", res.bucket, want.bucket);
        if (res.position != want.position)
          report_mismatch("position", res.position, want.position);
        if (res.pool_full != want.pool_full)
          report_mismatch("pool_full", res.pool_full, want.pool_full);
        if (res.collisions != want.collisions)
          report_mismatch("collisions", res.collisions, want.collisions);
        if (want.found && res.found) found_hits++;
        if (want.pool_full) drops++;
      end
      results_seen++;
    end
  end

  // counts cycles with no accepted item or result
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog expired");
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(input logic kind, input logic [KeyBits-1:0] key);
    in_item_t item;
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      cmd <= '{kind: 1'($urandom), key: KeyBits'($urandom)};
      repeat (gap) @(posedge clk);
    end
    item.kind = kind;
    item.key = key;
    start <= 1'b1;
    cmd <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_lookup(item));
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_size(input int size_val);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * RegTableSize);
    pwdata <= 32'(size_val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    clear_mirror(size_val & 32'h7f);
    size_settings++;
    @(posedge clk);
    if (prdata[SizeBits-1:0] != SizeBits'(size_val))
      report_mismatch("size readback", prdata[SizeBits-1:0], size_val);
  endtask

  task automatic test_directed();
    send_item(KindSearch, 16'h0000);
    send_item(KindInsert, 16'h0000);
    send_item(KindInsert, 16'hffff);
    send_item(KindInsert, 16'd11);
    send_item(KindInsert, 16'd22);
    send_item(KindInsert, 16'd22);
    send_item(KindSearch, 16'd0);
    send_item(KindSearch, 16'd11);
    send_item(KindSearch, 16'd22);
    send_item(KindSearch, 16'hffff);
    send_item(KindSearch, 16'd33);
    write_size(1);
    send_item(KindInsert, 16'h5555);
    send_item(KindInsert, 16'haaaa);
    send_item(KindSearch, 16'h5555);
    write_size(MaxBuckets);
    send_item(KindInsert, 16'd63);
    send_item(KindInsert, 16'hffff);
    send_item(KindSearch, 16'd127);
    // zero and out-of-range sizes
    write_size(0);
    send_item(KindInsert, 16'h1234);
    send_item(KindSearch, 16'h1234);
    write_size(127);
    send_item(KindInsert, 16'h8001);
    send_item(KindSearch, 16'h8001);
  endtask

  task automatic run_random_phase(input int size_val, input int count, input int key_span);
    logic [KeyBits-1:0] recent [$];
    logic [KeyBits-1:0] k;
    write_size(size_val);
    for (int i = 0; i < count; i++) begin
      if (recent.size() != 0 && $urandom_range(0, 2) == 0)
        k = recent[$urandom_range(0, recent.size() - 1)];
      else if ($urandom_range(0, 3) == 0)
        k = KeyBits'($urandom);
      else
        k = KeyBits'($urandom_range(0, key_span));
      if ($urandom_range(0, 1) == 0) begin
        send_item(KindInsert, k);
        recent.push_back(k);
      end else begin
        send_item(KindSearch, k);
      end
      if (i == count / 2) wait_drained();
    end
  endtask

  // 270 inserts, enough to run the pool dry
  task automatic test_pool_exhaustion();
    write_size(3);
    for (int i = 0; i < 300; i++)
      send_item((i % 10 == 9) ? KindSearch : KindInsert,
                KeyBits'($urandom_range(0, 40)));
    for (int i = 0; i < 20; i++) send_item(KindSearch, KeyBits'($urandom_range(0, 40)));
  endtask

  task automatic test_random();
    run_random_phase(11, 200, 300);
    run_random_phase(1, 150, 50);
    run_random_phase(64, 250, 2000);
    run_random_phase($urandom_range(2, 63), 200, 500);
    run_random_phase(7, 200, 65535);
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    size_settings = 0;
    found_hits = 0;
    drops = 0;
    start = 1'b0;
    cmd = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst = 1'b1;
    clear_mirror(SizeReset);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pool_exhaustion();
    test_random();
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    $display("%0d items over %0d table sizes, %0d results, %0d hits, %0d pool drops",
             items_sent, size_settings, results_seen, found_hits, drops);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d errors, %0d results outstanding", errors, expected_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ chained_hash_table.f @@
sv/chtab_pkg.sv
sv/chtab_ram.sv
sv/chained_hash_table.sv
tb/tb.sv
